// ----- sv/chained_hash_table_int_keys_defines.svh -----
// Assertion helpers shared by the hash table modules
`ifndef CHAINED_HASH_TABLE_INT_KEYS_DEFINES_SVH
`define CHAINED_HASH_TABLE_INT_KEYS_DEFINES_SVH

// checked only outside reset
`define CHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/cht_pkg.sv -----
package cht_pkg;

    localparam int NUM_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int NODE_W       = $clog2(POOL_ENTRIES);
    localparam int CNT_W        = NODE_W + 1;
    localparam int CFG_W        = 9;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_DEL   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [3:0] CMD_NONE   = 4'd0;
    localparam logic [3:0] CMD_LOAD   = 4'd1;
    localparam logic [3:0] CMD_CLEAR  = 4'd2;
    localparam logic [3:0] CMD_MOD    = 4'd3;
    localparam logic [3:0] CMD_TAIL   = 4'd4;
    localparam logic [3:0] CMD_FREE   = 4'd5;
    localparam logic [3:0] CMD_ALLOC  = 4'd6;
    localparam logic [3:0] CMD_PNODE  = 4'd7;
    localparam logic [3:0] CMD_PLINK  = 4'd8;
    localparam logic [3:0] CMD_FULL   = 4'd9;
    localparam logic [3:0] CMD_MISS   = 4'd10;
    localparam logic [3:0] CMD_WALK   = 4'd11;
    localparam logic [3:0] CMD_FETCH  = 4'd12;
    localparam logic [3:0] CMD_STEP   = 4'd13;
    localparam logic [3:0] CMD_HIT    = 4'd14;
    localparam logic [3:0] CMD_UNLINK = 4'd15;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [KEY_W-1:0] key;
        logic [31:0]             hash;
        logic [VAL_W-1:0]        value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      data_out;
        logic [CNT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic [3:0] cmd;
        logic       emit;
        logic       release_node;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       mod_done;
        logic       tail_ok;
        logic       free_avail;
        logic       fresh_avail;
        logic       hit;
        logic       cur_is_tail;
        logic       out_free;
    } t_stat;

endpackage

// ----- sv/cht_datapath.sv -----
`include "chained_hash_table_int_keys_defines.svh"

module cht_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cht_pkg::t_in_word          i_in_word,
    input  logic                       i_cfg_wr_en,
    input  logic [cht_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  cht_pkg::t_cmd              i_cmd,
    output cht_pkg::t_stat             o_stat,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output cht_pkg::t_out_word         o_out_word
);
    import cht_pkg::*;

    logic [NODE_W-1:0]       r_tail_mem [NUM_BUCKETS];
    logic [KEY_W-1:0]        r_key_mem  [POOL_ENTRIES];
    logic [VAL_W-1:0]        r_val_mem  [POOL_ENTRIES];
    logic [NODE_W-1:0]       r_link_mem [POOL_ENTRIES];
    logic [NUM_BUCKETS-1:0]  r_bkt_valid;

    logic [CFG_W-1:0]  r_cfg;
    logic [1:0]        r_op;
    logic [KEY_W-1:0]  r_key;
    logic [31:0]       r_hash;
    logic [VAL_W-1:0]  r_val;
    logic [CFG_W-1:0]  r_rem;
    logic [4:0]        r_step;
    logic              r_tail_ok;
    logic [NODE_W-1:0] r_tail_rd, r_link_rd, r_idx, r_prev, r_cur, r_free_head;
    logic [KEY_W-1:0]  r_key_rd;
    logic [VAL_W-1:0]  r_val_rd;
    logic [CNT_W-1:0]  r_free_len, r_fresh, r_count;
    logic [1:0]        r_res_status;
    logic [31:0]       r_res_data;

    logic [CFG_W-1:0]  n_mod;
    logic [CFG_W-1:0]  n_trial;
    logic [BKT_W-1:0]  n_bkt;
    logic              n_link_re, n_link_we, n_node_we, n_node_re, n_tail_we;
    logic [NODE_W-1:0] n_link_ra, n_link_wa, n_link_wd, n_tail_wd;

    assign n_mod   = (r_cfg == '0) ? CFG_W'(1) :
                     (r_cfg > CFG_W'(NUM_BUCKETS)) ? CFG_W'(NUM_BUCKETS) : r_cfg;
    assign n_trial = {r_rem[CFG_W-2:0], r_hash[31]};
    assign n_bkt   = r_rem[BKT_W-1:0];

    always_comb begin
        n_link_re = 1'b0;
        n_link_ra = r_tail_rd;
        n_link_we = 1'b0;
        n_link_wa = r_idx;
        n_link_wd = r_idx;
        n_node_we = 1'b0;
        n_node_re = 1'b0;
        n_tail_we = 1'b0;
        n_tail_wd = r_idx;
        case (i_cmd.cmd)
            CMD_FREE: begin
                n_link_re = 1'b1;
                n_link_ra = r_free_head;
            end
            CMD_ALLOC, CMD_WALK: begin
                n_link_re = 1'b1;
            end
            CMD_FETCH: begin
                n_link_re = 1'b1;
                n_link_ra = r_link_rd;
                n_node_re = 1'b1;
            end
            CMD_PNODE: begin
                n_node_we = 1'b1;
                n_link_we = 1'b1;
                n_link_wd = r_tail_ok ? r_link_rd : r_idx;
            end
            CMD_PLINK: begin
                n_link_we = r_tail_ok;
                n_link_wa = r_tail_rd;
                n_tail_we = 1'b1;
            end
            CMD_UNLINK: begin
                if (i_cmd.release_node) begin
                    n_link_we = 1'b1;
                    n_link_wa = r_cur;
                    n_link_wd = r_free_head;
                end else begin
                    n_link_we = (r_prev != r_cur);
                    n_link_wa = r_prev;
                    n_link_wd = r_link_rd;
                    n_tail_we = (r_prev != r_cur) && (r_tail_rd == r_cur);
                    n_tail_wd = r_prev;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_tail_we) begin
            r_tail_mem[n_bkt] <= n_tail_wd;
        end
        if (i_cmd.cmd == CMD_TAIL) begin
            r_tail_rd <= r_tail_mem[n_bkt];
        end
        if (n_link_we) begin
            r_link_mem[n_link_wa] <= n_link_wd;
        end
        if (n_link_re) begin
            r_link_rd <= r_link_mem[n_link_ra];
        end
        if (n_node_we) begin
            r_key_mem[r_idx] <= r_key;
            r_val_mem[r_idx] <= r_val;
        end
        if (n_node_re) begin
            r_key_rd <= r_key_mem[r_link_rd];
            r_val_rd <= r_val_mem[r_link_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.cmd)
            CMD_LOAD: begin
                r_op   <= i_in_word.operation;
                r_key  <= i_in_word.key;
                r_hash <= i_in_word.hash;
                r_val  <= i_in_word.value;
                r_rem  <= '0;
                r_step <= '0;
            end
            CMD_MOD: begin
                r_rem  <= (n_trial >= n_mod) ? n_trial - n_mod : n_trial;
                r_hash <= {r_hash[30:0], 1'b0};
                r_step <= r_step + 5'd1;
            end
            CMD_TAIL: r_tail_ok <= r_bkt_valid[n_bkt];
            CMD_WALK: r_prev <= r_tail_rd;
            CMD_FETCH: r_cur <= r_link_rd;
            CMD_STEP: r_prev <= r_cur;
            CMD_ALLOC: r_idx <= (r_free_len != '0) ? r_free_head : r_fresh[NODE_W-1:0];
            default: begin
            end
        endcase
        case (i_cmd.cmd)
            CMD_CLEAR, CMD_PLINK: begin
                r_res_status <= ST_OK;
                r_res_data   <= '0;
            end
            CMD_FULL: begin
                r_res_status <= ST_FULL;
                r_res_data   <= '0;
            end
            CMD_MISS: begin
                r_res_status <= ST_NOTFOUND;
                r_res_data   <= '0;
            end
            CMD_HIT, CMD_UNLINK: begin
                r_res_status <= ST_OK;
                r_res_data   <= 32'(r_val_rd);
            end
            default: begin
            end
        endcase
        if (i_cmd.emit) begin
            o_out_word.status      <= r_res_status;
            o_out_word.data_out    <= r_res_data;
            o_out_word.entry_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_W'(NUM_BUCKETS);
            r_bkt_valid <= '0;
            r_free_len  <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_free_head <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            case (i_cmd.cmd)
                CMD_CLEAR: begin
                    r_bkt_valid <= '0;
                    r_free_len  <= '0;
                    r_fresh     <= '0;
                    r_count     <= '0;
                end
                CMD_ALLOC: begin
                    if (r_free_len != '0) begin
                        r_free_head <= r_link_rd;
                        r_free_len  <= r_free_len - CNT_W'(1);
                    end else begin
                        r_fresh <= r_fresh + CNT_W'(1);
                    end
                end
                CMD_PLINK: begin
                    r_bkt_valid[n_bkt] <= 1'b1;
                    r_count            <= r_count + CNT_W'(1);
                end
                CMD_UNLINK: begin
                    if (i_cmd.release_node) begin
                        r_free_head <= r_cur;
                        r_free_len  <= r_free_len + CNT_W'(1);
                        r_count     <= r_count - CNT_W'(1);
                    end else if (r_prev == r_cur) begin
                        r_bkt_valid[n_bkt] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.mod_done    = (r_step == 5'd31);
    assign o_stat.tail_ok     = r_tail_ok;
    assign o_stat.free_avail  = (r_free_len != '0);
    assign o_stat.fresh_avail = (r_fresh < CNT_W'(POOL_ENTRIES));
    assign o_stat.hit         = (r_key_rd == r_key);
    assign o_stat.cur_is_tail = (r_cur == r_tail_rd);
    assign o_stat.out_free    = !o_out_valid || !i_out_stall;

    `CHT_ASSERT(a_count_balance, (i_cmd.emit |-> r_count == r_fresh - r_free_len), "entry count out of balance")
    `CHT_ASSERT(a_fresh_range, (r_fresh <= CNT_W'(POOL_ENTRIES)), "fresh pointer past pool")
    `CHT_ASSERT(a_status_code, (o_out_valid |-> o_out_word.status != 2'd3), "bad status code")

endmodule

// ----- sv/cht_ctrl.sv -----
`include "chained_hash_table_int_keys_defines.svh"

module cht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cht_pkg::t_stat i_stat,
    output cht_pkg::t_cmd  o_cmd
);
    import cht_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_TAIL   = 4'd3;
    localparam logic [3:0] S_BRANCH = 4'd4;
    localparam logic [3:0] S_FREE   = 4'd5;
    localparam logic [3:0] S_ALLOC  = 4'd6;
    localparam logic [3:0] S_PNODE  = 4'd7;
    localparam logic [3:0] S_PLINK  = 4'd8;
    localparam logic [3:0] S_WALK   = 4'd9;
    localparam logic [3:0] S_FETCH  = 4'd10;
    localparam logic [3:0] S_CHECK  = 4'd11;
    localparam logic [3:0] S_DEL1   = 4'd12;
    localparam logic [3:0] S_DEL2   = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state            = r_state;
        o_cmd.cmd          = CMD_NONE;
        o_cmd.emit         = 1'b0;
        o_cmd.release_node = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cmd = CMD_LOAD;
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (i_stat.op == OP_CLEAR) begin
                    o_cmd.cmd = CMD_CLEAR;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.cmd = CMD_MOD;
                if (i_stat.mod_done) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.cmd = CMD_TAIL;
                n_state   = S_BRANCH;
            end
            S_BRANCH: begin
                if (i_stat.op == OP_PUT) begin
                    if (i_stat.free_avail) begin
                        n_state = S_FREE;
                    end else if (i_stat.fresh_avail) begin
                        n_state = S_ALLOC;
                    end else begin
                        o_cmd.cmd = CMD_FULL;
                        n_state   = S_DONE;
                    end
                end else if (i_stat.tail_ok) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.cmd = CMD_MISS;
                    n_state   = S_DONE;
                end
            end
            S_FREE: begin
                o_cmd.cmd = CMD_FREE;
                n_state   = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.cmd = CMD_ALLOC;
                n_state   = S_PNODE;
            end
            S_PNODE: begin
                o_cmd.cmd = CMD_PNODE;
                n_state   = S_PLINK;
            end
            S_PLINK: begin
                o_cmd.cmd = CMD_PLINK;
                n_state   = S_DONE;
            end
            S_WALK: begin
                o_cmd.cmd = CMD_WALK;
                n_state   = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.cmd = CMD_FETCH;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    if (i_stat.op == OP_DEL) begin
                        n_state = S_DEL1;
                    end else begin
                        o_cmd.cmd = CMD_HIT;
                        n_state   = S_DONE;
                    end
                end else if (i_stat.cur_is_tail) begin
                    o_cmd.cmd = CMD_MISS;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.cmd = CMD_STEP;
                    n_state   = S_FETCH;
                end
            end
            S_DEL1: begin
                o_cmd.cmd = CMD_UNLINK;
                n_state   = S_DEL2;
            end
            S_DEL2: begin
                o_cmd.cmd          = CMD_UNLINK;
                o_cmd.release_node = 1'b1;
                n_state            = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `CHT_ASSERT(a_accept_starts, ((r_state == S_IDLE && i_in_valid) |=> r_state == S_START), "accepted word not started")
    `CHT_ASSERT(a_emit_in_done, (o_cmd.emit |-> r_state == S_DONE && i_stat.out_free), "emit outside done")
    `CHT_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n |=> r_state == S_IDLE), "not idle after reset")

endmodule

// ----- sv/chained_hash_table_int_keys.sv -----
// Chained hash table, integer keys, node pool of 1024 entries, up to 256 buckets.
// Input channel: i_in_valid / o_in_stall carry i_in_word (operation, key, hash,
// value). Output channel: o_out_valid / i_out_stall carry o_out_word (status,
// data_out, entry_count). A word moves when valid is high and stall is low.
// Every input word gives exactly one output word.
// Bucket count is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, as the block does not enforce it. 0 acts as 1 and
// values above 256 act as 256. One word at a time. The bucket index comes from
// a bit-serial modulo over the 32 hash bits, then registered memory reads.
// Clear goes straight to the output. Put takes a node from the free list or
// the unused pool and links it into the bucket, or reports full; get walks the
// bucket's chain node by node (empty bucket: miss); delete also unlinks on a hit.
// The next word is accepted the cycle after the output word is loaded.
// Reset (i_rst_n low, synchronous) empties all buckets at once through per-bucket
// valid bits, empties the pool and sets bucket count to 256; no clearing pass.
// If the receiver stalls, the result waits in the output register and the
// table holds the finished state until the word is taken.
module chained_hash_table_int_keys (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cht_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cht_pkg::t_out_word         o_out_word,
    input  logic                       i_cfg_wr_en,
    input  logic [cht_pkg::CFG_W-1:0]  i_cfg_wr_data
);
    import cht_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cht_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

endmodule

// ----- tb/tb_chained_hash_table_int_keys.sv -----
`timescale 1ns / 1ps

class hash_table_scoreboard;
    localparam int NB = cht_pkg::NUM_BUCKETS;
    localparam int NP = cht_pkg::POOL_ENTRIES;

    int unsigned tail_node [NB];
    bit          bucket_used [NB];
    logic [31:0] node_key [NP];
    logic [31:0] node_val [NP];
    int unsigned node_next [NP];
    int unsigned free_top;
    int unsigned free_len;
    int unsigned fresh_idx;
    int unsigned entries;
    int unsigned buckets_cfg;
    cht_pkg::t_out_word pending[$];
    int errors;

    function new();
        errors = 0;
        buckets_cfg = 256;
        empty_all();
    endfunction

    function void empty_all();
        for (int i = 0; i < NB; i++) begin
            tail_node[i] = 0;
            bucket_used[i] = 0;
        end
        free_top = 0;
        free_len = 0;
        fresh_idx = 0;
        entries = 0;
    endfunction

    function void set_buckets(logic [8:0] v);
        buckets_cfg = v;
    endfunction

    function bit lookup(int unsigned b, logic [31:0] k, output int unsigned hit,
                        output int unsigned prev);
        int unsigned t;
        int unsigned cur;
        hit = 0;
        prev = 0;
        if (!bucket_used[b]) return 0;
        t = tail_node[b];
        prev = t;
        cur = node_next[t];
        for (int s = 0; s < NP; s++) begin
            if (node_key[cur] == k) begin
                hit = cur;
                return 1;
            end
            if (cur == t) return 0;
            prev = cur;
            cur = node_next[cur];
        end
        return 0;
    endfunction

    function void note_word(cht_pkg::t_in_word w);
        cht_pkg::t_out_word r;
        int unsigned n;
        int unsigned b;
        int unsigned idx;
        int unsigned prv;
        bit got;
        n = buckets_cfg;
        if (n == 0) n = 1;
        if (n > NB) n = NB;
        b = w.hash % n;
        r.status = cht_pkg::ST_OK;
        r.data_out = '0;
        case (w.operation)
            cht_pkg::OP_PUT: begin
                got = 1;
                if (free_len > 0) begin
                    idx = free_top;
                    free_top = node_next[idx];
                    free_len--;
                end else if (fresh_idx < NP) begin
                    idx = fresh_idx++;
                end else begin
                    got = 0;
                end
                if (!got) begin
                    r.status = cht_pkg::ST_FULL;
                end else begin
                    node_key[idx] = w.key;
                    node_val[idx] = w.value;
                    if (!bucket_used[b]) begin
                        node_next[idx] = idx;
                        bucket_used[b] = 1;
                    end else begin
                        node_next[idx] = node_next[tail_node[b]];
                        node_next[tail_node[b]] = idx;
                    end
                    tail_node[b] = idx;
                    entries++;
                end
            end
            cht_pkg::OP_GET: begin
                if (lookup(b, w.key, idx, prv)) r.data_out = node_val[idx];
                else r.status = cht_pkg::ST_NOTFOUND;
            end
            cht_pkg::OP_DEL: begin
                if (lookup(b, w.key, idx, prv)) begin
                    r.data_out = node_val[idx];
                    if (prv == idx) begin
                        bucket_used[b] = 0;
                        tail_node[b] = 0;
                    end else begin
                        node_next[prv] = node_next[idx];
                        if (tail_node[b] == idx) tail_node[b] = prv;
                    end
                    node_next[idx] = free_top;
                    free_top = idx;
                    free_len++;
                    if (entries > 0) entries--;
                end else begin
                    r.status = cht_pkg::ST_NOTFOUND;
                end
            end
            default: empty_all();
        endcase
        r.entry_count = entries[cht_pkg::CNT_W-1:0];
        pending.push_back(r);
    endfunction

    function void check_word(cht_pkg::t_out_word got);
        cht_pkg::t_out_word exp_w;
        if (pending.size() == 0) begin
            $error("unexpected output word %h", got);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        if (got.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, got.status);
            errors++;
        end
        if (got.data_out !== exp_w.data_out) begin
            $error("data_out: expected %h, got %h", exp_w.data_out, got.data_out);
            errors++;
        end
        if (got.entry_count !== exp_w.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_w.entry_count,
                   got.entry_count);
            errors++;
        end
    endfunction
endclass

module tb_chained_hash_table_int_keys;
    import cht_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_word i_in_word;
    logic o_out_valid;
    logic i_out_stall;
    t_out_word o_out_word;
    logic i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    hash_table_scoreboard sb;
    int idle_cycles;
    bit hold_rx;
    bit rx_random;
    logic [31:0] key_pool [16];

    chained_hash_table_int_keys u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_out_stall = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = '0;
    end

    // accepted and taken words, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_word(i_in_word);
            if (o_out_valid && !i_out_stall) sb.check_word(o_out_word);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver
    initial begin
        int r;
        hold_rx = 0;
        rx_random = 0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1;
                repeat (600) @(posedge i_clk);
                hold_rx = 0;
                i_out_stall <= 0;
            end else if (rx_random) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    i_out_stall <= 1;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                    i_out_stall <= 0;
                end else if (r < 22) begin
                    i_out_stall <= 1;
                    repeat ($urandom_range(30, 150)) @(posedge i_clk);
                    i_out_stall <= 0;
                end
            end
        end
    end

    // valid stays high between back-to-back words; it drops only for a gap or in drain
    task automatic send_word(logic [1:0] op, logic [31:0] k, logic [31:0] h,
                             logic [31:0] v, bit gaps);
        int r;
        int n;
        n = 0;
        if (gaps) begin
            r = $urandom_range(0, 99);
            if (r < 25) n = $urandom_range(1, 5);
            else if (r < 27) n = $urandom_range(40, 120);
        end
        if (n > 0) begin
            i_in_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_in_word.operation <= op;
        i_in_word.key <= k;
        i_in_word.hash <= h;
        i_in_word.value <= v;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [8:0] v);
        drain();
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.set_buckets(v);
    endtask

    task automatic random_phase(int n);
        logic [1:0] op;
        int r;
        int ki;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            ki = $urandom_range(0, 15);
            if (r < 40) op = OP_PUT;
            else if (r < 70) op = OP_GET;
            else if (r < 99) op = OP_DEL;
            else op = OP_CLEAR;
            if ($urandom_range(0, 9) == 0)
                send_word(op, $urandom, $urandom, $urandom, 1);
            else
                send_word(op, key_pool[ki], key_pool[ki] ^ 32'h5a5a_0000,
                          $urandom, 1);
        end
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'hffff_ffff;
        key_pool[3] = 32'h0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send_word(OP_GET, 32'h0, 32'h0, 32'h0, 0);
        send_word(OP_DEL, 32'h0, 32'h0, 32'h0, 0);
        send_word(OP_PUT, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_word(OP_PUT, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 0);
        send_word(OP_PUT, 32'h8000_0000, 32'hffff_ffff, 32'h1234_5678, 0);
        send_word(OP_GET, 32'h8000_0000, 32'hffff_ffff, 32'h0, 0);
        send_word(OP_DEL, 32'h8000_0000, 32'hffff_ffff, 32'h0, 0);
        send_word(OP_GET, 32'h8000_0000, 32'hffff_ffff, 32'h0, 0);
        send_word(OP_DEL, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 0);
        send_word(OP_GET, 32'h7fff_ffff, 32'h0, 32'h0, 0);
        send_word(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_word(OP_GET, 32'h8000_0000, 32'hffff_ffff, 32'h0, 0);
        write_buckets(9'd0);
        send_word(OP_PUT, 32'd5, 32'd77, 32'd9, 0);
        send_word(OP_PUT, 32'd6, 32'd3, 32'd10, 0);
        write_buckets(9'd511);
        send_word(OP_GET, 32'd5, 32'd77, 32'd0, 0);
        send_word(OP_GET, 32'd6, 32'd3, 32'd0, 0);
        write_buckets(9'd1);
        // fill the pool, exercising the full status and a long stall
        hold_rx = 1;
        for (int i = 0; i < POOL_ENTRIES + 2; i++)
            send_word(OP_PUT, i, $urandom, $urandom, 0);
        send_word(OP_DEL, 32'd3, 32'd0, 32'd0, 0);
        send_word(OP_PUT, 32'd3000, 32'd0, 32'd1, 0);
        send_word(OP_CLEAR, 32'd0, 32'd0, 32'd0, 0);

        rx_random = 1;
        write_buckets(9'd256);
        random_phase(60);
        write_buckets(9'd1);
        random_phase(40);
        write_buckets(9'd3);
        random_phase(60);
        write_buckets(9'd17);
        random_phase(60);
        write_buckets(9'd300);
        random_phase(30);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
